[sv/double_ended_queue_unit_assert.svh]
// Assertion macros used by the queue control module.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge, skipped while reset is low.
`define DEQU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("deque assertion failed");

// Check a property on every rising edge, reset included.
`define DEQU_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("deque assertion failed");

`else

`define DEQU_ASSERT(lbl, clk, rst_n, prop)
`define DEQU_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[sv/deq_pkg.sv]
package deq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int IN_DATA_W      = 32;
    localparam int COUNT_W        = 5;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT  = 3'd0,
        OP_PUSH_BACK   = 3'd1,
        OP_POP_FRONT   = 3'd2,
        OP_POP_BACK    = 3'd3,
        OP_CLEAR       = 3'd4,
        OP_CHECK_FRONT = 3'd5,
        OP_CHECK_BACK  = 3'd6,
        OP_QUERY       = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        t_opcode                       opcode;
        logic signed [IN_DATA_W-1:0]   data_value;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        logic [COUNT_W-1:0]   entry_count;
        logic                 is_empty;
    } t_out_item;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

endpackage

[sv/deq_ctrl.sv]
`include "double_ended_queue_unit_assert.svh"

module deq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output deq_pkg::t_dp_cmd o_cmd
);

    deq_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= deq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            deq_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = deq_pkg::S_EXEC;
                end
            end
            deq_pkg::S_EXEC: begin
                // finish only once the result slot is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.execute = 1'b1;
                    n_state       = deq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = deq_pkg::S_IDLE;
            end
        endcase

        if (o_cmd.execute) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `DEQU_ASSERT(a_exec_loads_result, i_clk, i_rst_n, o_cmd.execute |=> o_out_valid)
    `DEQU_ASSERT(a_no_overwrite, i_clk, i_rst_n, (r_out_valid && !i_out_ready) |-> !o_cmd.execute)
    `DEQU_ASSERT(a_capture_then_busy, i_clk, i_rst_n, o_cmd.capture |=> !o_in_ready)
    `DEQU_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (o_in_ready && !o_out_valid))

endmodule

[sv/deq_dp.sv]
module deq_dp #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  deq_pkg::t_dp_cmd   i_cmd,
    input  deq_pkg::t_in_item  i_in_item,
    output deq_pkg::t_out_item o_out_item
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] idx);
        return (idx == LAST_SLOT) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] idx);
        return (idx == '0) ? LAST_SLOT : idx - 1'b1;
    endfunction

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [AW-1:0]         r_front, n_front;
    logic [AW-1:0]         r_back, n_back;
    logic [CW-1:0]         r_count, n_count;
    deq_pkg::t_opcode      r_op;
    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] r_rd_data;
    deq_pkg::t_out_item    r_out_item, n_out_item;

    logic [DATA_WIDTH+deq_pkg::IN_DATA_W-1:0] w_in_ext;
    logic [DATA_WIDTH-1:0]                    w_in_val;
    logic [AW-1:0]                            w_back_prev;
    logic [AW-1:0]                            w_rd_addr;
    logic                                     w_wr_en;
    logic [AW-1:0]                            w_wr_addr;
    logic                                     w_full, w_empty;
    deq_pkg::t_status                         w_status;
    logic [CW+deq_pkg::COUNT_W-1:0]           w_cnt_ext;

    // stored value is the low DATA_WIDTH bits of the input word
    assign w_in_ext = {{DATA_WIDTH{1'b0}}, unsigned'(i_in_item.data_value)};
    assign w_in_val = w_in_ext[DATA_WIDTH-1:0];

    assign w_back_prev = slot_prev(r_back);
    assign w_rd_addr   = (i_in_item.opcode == deq_pkg::OP_CHECK_BACK) ? w_back_prev : r_front;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_in_item.opcode;
            r_data    <= w_in_val;
            r_rd_data <= mem[w_rd_addr];
        end
        if (w_wr_en) begin
            mem[w_wr_addr] <= r_data;
        end
        if (i_cmd.execute) begin
            r_out_item <= n_out_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else if (i_cmd.execute) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

    assign w_full  = (r_count == FULL_CNT);
    assign w_empty = (r_count == '0);

    always_comb begin
        n_front   = r_front;
        n_back    = r_back;
        n_count   = r_count;
        w_status  = deq_pkg::ST_OK;
        w_wr_en   = 1'b0;
        w_wr_addr = r_back;
        case (r_op)
            deq_pkg::OP_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = deq_pkg::ST_FULL;
                end else begin
                    n_front   = slot_prev(r_front);
                    w_wr_addr = n_front;
                    w_wr_en   = i_cmd.execute;
                    n_count   = r_count + 1'b1;
                end
            end
            deq_pkg::OP_PUSH_BACK: begin
                if (w_full) begin
                    w_status = deq_pkg::ST_FULL;
                end else begin
                    w_wr_addr = r_back;
                    w_wr_en   = i_cmd.execute;
                    n_back    = slot_next(r_back);
                    n_count   = r_count + 1'b1;
                end
            end
            deq_pkg::OP_POP_FRONT: begin
                if (w_empty) begin
                    w_status = deq_pkg::ST_EMPTY;
                end else begin
                    n_front = slot_next(r_front);
                    n_count = r_count - 1'b1;
                end
            end
            deq_pkg::OP_POP_BACK: begin
                if (w_empty) begin
                    w_status = deq_pkg::ST_EMPTY;
                end else begin
                    n_back  = w_back_prev;
                    n_count = r_count - 1'b1;
                end
            end
            deq_pkg::OP_CLEAR: begin
                n_front = '0;
                n_back  = '0;
                n_count = '0;
            end
            deq_pkg::OP_CHECK_FRONT, deq_pkg::OP_CHECK_BACK: begin
                if (w_empty) begin
                    w_status = deq_pkg::ST_EMPTY;
                end else if (r_rd_data != r_data) begin
                    w_status = deq_pkg::ST_MISMATCH;
                end
            end
            default: begin
            end
        endcase
    end

    assign w_cnt_ext = {{deq_pkg::COUNT_W{1'b0}}, n_count};

    always_comb begin
        n_out_item.status      = w_status;
        n_out_item.entry_count = w_cnt_ext[deq_pkg::COUNT_W-1:0];
        n_out_item.is_empty    = (n_count == '0);
    end

    assign o_out_item = r_out_item;

endmodule

[sv/double_ended_queue_unit.sv]
// Bounded double-ended queue of DATA_WIDTH-bit words in a ring of DEPTH entries. Each input
// transaction carries an opcode (push or pop at either end, clear, compare the front or back
// entry with the value, or query) and yields exactly one result transaction with a status,
// the entry count after the operation (low five bits) and an empty flag. The entry that a
// compare needs is read from the ring memory, whose read data is registered, in the accept
// cycle; pointers, count and the ring are updated when the item executes. A new item is
// taken while a result still waits in the output register; the block holds a finished item
// only while that register stays full.
module double_ended_queue_unit #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  deq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output deq_pkg::t_out_item o_out_item
);

    deq_pkg::t_dp_cmd w_cmd;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    deq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item)
    );

endmodule

[verif/tb_double_ended_queue_unit.sv]
`timescale 1ns / 100ps

module tb_double_ended_queue_unit;
    import deq_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int DATA_WIDTH   = DATA_WIDTH_DEF;
    localparam int RANDOM_ITEMS = 800;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam int MAX_PRINTS   = 40;

    typedef struct {
        t_opcode     op;
        logic [31:0] value;
        int          reps;
        bit          known;
        t_out_item   want;
    } t_dir_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    // typed-in expectation travels alongside the input transaction
    logic      typed_known = 1'b0;
    t_out_item typed_want = '0;

    // predictor state
    logic [DATA_WIDTH-1:0] ring_slots [DEPTH];
    int                    head_slot;
    int                    tail_slot;
    int                    fill_level;

    t_out_item          pending_results [$];
    logic [31:0]        stim_mirror [$];
    t_dir_row           dir_rows [$];
    int                 errors = 0;
    int                 idle_cycles = 0;
    int                 hold_requests = 0;
    int                 holds_served = 0;
    int                 hold_left = 0;
    int                 rx_phase_left = 0;
    int                 rx_mode = 0;
    int                 rx_tick = 0;

    double_ended_queue_unit #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic void ring_reset();
        head_slot  = 0;
        tail_slot  = 0;
        fill_level = 0;
    endfunction

    // Apply one operation to the predicted ring and return the result it yields.
    function automatic t_out_item deque_apply(input t_in_item it);
        t_out_item             res;
        logic [DATA_WIDTH-1:0] word;
        word       = it.data_value[DATA_WIDTH-1:0];
        res.status = ST_OK;
        case (it.opcode)
            OP_PUSH_FRONT: begin
                if (fill_level >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    head_slot = (head_slot + DEPTH - 1) % DEPTH;
                    ring_slots[head_slot] = word;
                    fill_level++;
                end
            end
            OP_PUSH_BACK: begin
                if (fill_level >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    ring_slots[tail_slot] = word;
                    tail_slot = (tail_slot + 1) % DEPTH;
                    fill_level++;
                end
            end
            OP_POP_FRONT: begin
                if (fill_level == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    head_slot = (head_slot + 1) % DEPTH;
                    fill_level--;
                end
            end
            OP_POP_BACK: begin
                if (fill_level == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    tail_slot = (tail_slot + DEPTH - 1) % DEPTH;
                    fill_level--;
                end
            end
            OP_CLEAR: begin
                ring_reset();
            end
            OP_CHECK_FRONT: begin
                if (fill_level == 0) res.status = ST_EMPTY;
                else if (ring_slots[head_slot] != word) res.status = ST_MISMATCH;
            end
            OP_CHECK_BACK: begin
                if (fill_level == 0) res.status = ST_EMPTY;
                else if (ring_slots[(tail_slot + DEPTH - 1) % DEPTH] != word)
                    res.status = ST_MISMATCH;
            end
            default: ;
        endcase
        res.entry_count = fill_level[COUNT_W-1:0];
        res.is_empty    = (fill_level == 0);
        return res;
    endfunction

    // Predict on input transactions, check output transactions.
    always @(posedge i_clk) begin
        t_out_item pred;
        t_out_item want;
        if (i_rst_n) begin
            if (in_valid && o_in_ready) begin
                pred = deque_apply(in_item);
                pending_results.push_back(typed_known ? typed_want : pred);
            end
            if (o_out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result transaction with nothing expected");
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_item.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                        o_out_item.status, want.status));
                    if (o_out_item.entry_count !== want.entry_count)
                        report_mismatch($sformatf("entry_count got %0d want %0d",
                                        o_out_item.entry_count, want.entry_count));
                    if (o_out_item.is_empty !== want.is_empty)
                        report_mismatch($sformatf("is_empty got %0b want %0b",
                                        o_out_item.is_empty, want.is_empty));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL double_ended_queue_unit");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: phases of always-ready, random and periodic stalls, plus long holds on request.
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            out_ready    <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end else begin
            if (rx_phase_left == 0) begin
                rx_mode       <= $urandom_range(0, 2);
                rx_phase_left <= $urandom_range(20, 200);
            end else begin
                rx_phase_left <= rx_phase_left - 1;
            end
            case (rx_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ((rx_tick % 7) < 3);
            endcase
        end
    end

    task automatic drive_item(input t_in_item it, input bit known, input t_out_item want);
        in_item     <= it;
        in_valid    <= 1'b1;
        typed_known <= known;
        typed_want  <= want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic add_row(input t_opcode op, input logic [31:0] value, input int reps,
                           input bit known, input t_status st, input int cnt);
        t_dir_row r;
        r.op               = op;
        r.value            = value;
        r.reps             = reps;
        r.known            = known;
        r.want.status      = st;
        r.want.entry_count = cnt[COUNT_W-1:0];
        r.want.is_empty    = (cnt == 0);
        dir_rows.push_back(r);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Draw one operation; mostly valid checks against the mirrored contents.
    function automatic t_in_item make_item(input int bias);
        t_in_item it;
        int       roll;
        int       push_pct;
        int       pop_pct;
        logic [31:0] v;
        push_pct = (bias == 0) ? 55 : (bias == 1) ? 20 : 35;
        pop_pct  = (bias == 0) ? 15 : (bias == 1) ? 50 : 30;
        roll     = $urandom_range(0, 99);
        v        = pick_value();
        if (roll < push_pct) begin
            it.opcode = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            if (stim_mirror.size() < DEPTH) begin
                if (it.opcode == OP_PUSH_FRONT) stim_mirror.push_front(v);
                else stim_mirror.push_back(v);
            end
        end else if (roll < push_pct + pop_pct) begin
            it.opcode = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
            if (stim_mirror.size() != 0) begin
                if (it.opcode == OP_POP_FRONT) void'(stim_mirror.pop_front());
                else void'(stim_mirror.pop_back());
            end
        end else if (roll < 95) begin
            it.opcode = $urandom_range(0, 1) ? OP_CHECK_FRONT : OP_CHECK_BACK;
            if (stim_mirror.size() != 0 && $urandom_range(0, 4) != 0)
                v = (it.opcode == OP_CHECK_FRONT) ? stim_mirror[0] : stim_mirror[$];
        end else if (roll < 96) begin
            it.opcode = OP_CLEAR;
            stim_mirror.delete();
        end else begin
            it.opcode = OP_QUERY;
        end
        it.data_value = v;
        return it;
    endfunction

    initial begin
        t_in_item  it;
        t_out_item none;
        int        burst_left;
        int        gap;
        int        bias;
        none = '0;
        ring_reset();

        add_row(OP_QUERY,       32'h0000_0000,  1, 1, ST_OK,    0);
        add_row(OP_POP_FRONT,   32'h0000_0000,  1, 1, ST_EMPTY, 0);
        add_row(OP_POP_BACK,    32'hFFFF_FFFF,  1, 1, ST_EMPTY, 0);
        add_row(OP_CHECK_FRONT, 32'h0000_0000,  1, 1, ST_EMPTY, 0);
        add_row(OP_CHECK_BACK,  32'hFFFF_FFFF,  1, 1, ST_EMPTY, 0);
        add_row(OP_PUSH_BACK,   32'h7FFF_FFFF,  1, 0, ST_OK,    0);
        add_row(OP_PUSH_FRONT,  32'h8000_0000,  1, 0, ST_OK,    0);
        add_row(OP_CHECK_FRONT, 32'h8000_0000,  1, 0, ST_OK,    0);
        add_row(OP_CHECK_BACK,  32'h7FFF_FFFF,  1, 0, ST_OK,    0);
        add_row(OP_CHECK_FRONT, 32'h0000_0000,  1, 0, ST_OK,    0);
        add_row(OP_CHECK_BACK,  32'hFFFF_FFFF,  1, 0, ST_OK,    0);
        add_row(OP_PUSH_BACK,   32'h5A5A_A5A5, 14, 0, ST_OK,    0);
        add_row(OP_PUSH_FRONT,  32'h1234_5678,  1, 1, ST_FULL,  DEPTH);
        add_row(OP_PUSH_BACK,   32'h1234_5678,  1, 1, ST_FULL,  DEPTH);
        add_row(OP_CHECK_FRONT, 32'h8000_0000,  1, 0, ST_OK,    0);
        add_row(OP_CHECK_BACK,  32'h5A5A_A5A5,  1, 0, ST_OK,    0);
        add_row(OP_POP_FRONT,   32'h0000_0000,  1, 0, ST_OK,    0);
        add_row(OP_POP_BACK,    32'h0000_0000,  1, 0, ST_OK,    0);
        add_row(OP_CLEAR,       32'h0000_0000,  1, 1, ST_OK,    0);
        add_row(OP_QUERY,       32'hFFFF_FFFF,  1, 1, ST_OK,    0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            for (int k = 0; k < dir_rows[r].reps; k++) begin
                it.opcode     = dir_rows[r].op;
                it.data_value = dir_rows[r].value;
                drive_item(it, dir_rows[r].known, dir_rows[r].want);
            end
        end

        // directed part ends with a clear, so the mirror starts out empty
        stim_mirror.delete();
        burst_left = 0;
        bias       = 2;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) bias = $urandom_range(0, 2);
            if (n == 300 || n == 650) hold_requests++;
            if (n == 500) begin
                // let the block drain completely before going on
                in_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
                repeat (4) @(posedge i_clk);
            end else if (burst_left == 0) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 6);
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 20);
            end
            drive_item(make_item(bias), 1'b0, none);
            if (burst_left > 0) burst_left--;
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS double_ended_queue_unit");
        end else begin
            $display("FAIL double_ended_queue_unit");
        end
        $finish;
    end

endmodule

[double_ended_queue_unit.f]
+incdir+sv
sv/deq_pkg.sv
sv/deq_ctrl.sv
sv/deq_dp.sv
sv/double_ended_queue_unit.sv
verif/tb_double_ended_queue_unit.sv
